/* rtl/packed_palette_index_unpacker_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packed palette index unpacker
// Clocked on aclk, disabled while aresetn is low; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PACKED_PALETTE_INDEX_UNPACKER_TOP_ASSERT_SVH
`define PACKED_PALETTE_INDEX_UNPACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// holds at every edge out of reset
`define PPIU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// consequent holds after the antecedent (non-overlapping implication)
`define PPIU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPIU_ASSERT(label, prop, msg)
`define PPIU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/ppiu_pkg.sv */
// ----------------------------------------------------------------------------
// ppiu_pkg
// Constants and helper functions for the packed palette index unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package ppiu_pkg;

    localparam int BLOCKS_PER_SECTION_DEF = 4096;
    localparam int MAX_ENTRY_BITS_DEF     = 12;
    localparam int WORD_BITS              = 64;
    localparam int MIN_ENTRY_BITS         = 4;
    localparam int PALETTE_W              = 13;
    localparam int INDEX_W                = 12;
    localparam int BLOCK_NUM_W            = 12;
    localparam int WIDTH_W                = 5;
    localparam int REM_W                  = 5;
    localparam int TDATA_W                = 24;
    localparam int TUSER_W                = 2;

    localparam logic [PALETTE_W-1:0] PALETTE_SIZE_RESET = 13'd16;

    // max(MIN_ENTRY_BITS, ceil(log2(n))), capped at max_bits
    function automatic logic [WIDTH_W-1:0] entry_width(
        input logic [PALETTE_W-1:0] n,
        input int                   max_bits
    );
        logic [WIDTH_W-1:0] w;
        w = '0;
        for (int i = 0; i < 16; i++) begin
            if ((17'd1 << i) < {4'd0, n}) begin
                w = WIDTH_W'(i + 1);
            end
        end
        if (w < WIDTH_W'(MIN_ENTRY_BITS)) begin
            w = WIDTH_W'(MIN_ENTRY_BITS);
        end
        if (w > WIDTH_W'(max_bits)) begin
            w = WIDTH_W'(max_bits);
        end
        return w;
    endfunction

    // entries that fit in one 64-bit word without spanning
    function automatic logic [REM_W-1:0] entries_per_word(input logic [WIDTH_W-1:0] w);
        logic [REM_W-1:0] per;
        case (w)
            5'd4:    per = 5'd16;
            5'd5:    per = 5'd12;
            5'd6:    per = 5'd10;
            5'd7:    per = 5'd9;
            5'd8:    per = 5'd8;
            5'd9:    per = 5'd7;
            5'd10:   per = 5'd6;
            5'd11:   per = 5'd5;
            5'd12:   per = 5'd5;
            5'd13:   per = 5'd4;
            5'd14:   per = 5'd4;
            5'd15:   per = 5'd4;
            5'd16:   per = 5'd4;
            default: per = 5'd16;
        endcase
        return per;
    endfunction

endpackage

`default_nettype wire

/* rtl/packed_palette_index_unpacker_top.sv */
// ----------------------------------------------------------------------------
// packed_palette_index_unpacker_top
// Unpacks 64-bit words of fixed-width palette indices, one index per beat.
//
// s_* channel: one 64-bit packed word per beat. m_* channel: one palette
// index per beat, with its block number, an out-of-palette flag, the last
// entry of the word on m_tlast and the last entry of the section on
// m_tuser[1]. cfg_wr_en/cfg_wr_data set the palette size; the user must
// write it only while idle, as the block does not enforce this. The size
// fixes the entry width W = max(4, ceil(log2(size))), capped at
// MAX_ENTRY_BITS; a word yields floor(64/W) entries, low bits first.
// One 64-bit shifter, driven by a small sequencer, peels one entry per cycle
// while the output is not stalled. s_tready is low while a word is being
// unpacked. A stalled output holds its beat in the output register and
// the shifter waits.
// Reset: palette size 16, block counter 0, both channels empty. The block
// counter wraps after BLOCKS_PER_SECTION entries; the rest of that word is
// dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_palette_index_unpacker_top_assert.svh"

module packed_palette_index_unpacker_top
    import ppiu_pkg::*;
#(
    parameter int BLOCKS_PER_SECTION = BLOCKS_PER_SECTION_DEF,
    parameter int MAX_ENTRY_BITS     = MAX_ENTRY_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [PALETTE_W-1:0]   cfg_wr_data,   // palette_size

    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [WORD_BITS-1:0]   s_tdata,       // packed_word

    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [TDATA_W-1:0]     m_tdata,       // palette_index[11:0], block_number[23:12]
    output      logic                   m_tlast,       // last_of_word
    output      logic [TUSER_W-1:0]     m_tuser        // out_of_palette[0], last_of_section[1]
);

    localparam int CNT_W = $clog2(BLOCKS_PER_SECTION);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCKS_PER_SECTION - 1);
    localparam int CMP_W = (MAX_ENTRY_BITS > PALETTE_W) ? MAX_ENTRY_BITS + 1 : PALETTE_W + 1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                     state_reg,   state_next;
    logic [PALETTE_W-1:0]       palette_reg, palette_next;
    logic [WIDTH_W-1:0]         width_reg,   width_next;
    logic [REM_W-1:0]           per_reg,     per_next;
    logic [REM_W-1:0]           remain_reg,  remain_next;
    logic [CNT_W-1:0]           cnt_reg,     cnt_next;
    logic [WORD_BITS-1:0]       word_reg,    word_next;
    logic                       m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]         pidx_reg,    pidx_next;
    logic [BLOCK_NUM_W-1:0]     bnum_reg,    bnum_next;
    logic                       oop_reg,     oop_next;
    logic                       low_reg,     low_next;
    logic                       los_reg,     los_next;

    logic                       emit;
    logic                       sec_end;
    logic                       last_entry;
    logic [MAX_ENTRY_BITS-1:0]  idx;
    logic [MAX_ENTRY_BITS+INDEX_W-1:0] idx_ext;
    logic [CNT_W+BLOCK_NUM_W-1:0]      cnt_ext;

    assign emit       = (state_reg == ST_RUN) && (!m_valid_reg || m_tready);
    assign sec_end    = (cnt_reg == CNT_LAST);
    assign last_entry = sec_end || (remain_reg == REM_W'(1));
    assign idx        = word_reg[MAX_ENTRY_BITS-1:0]
                        & ~({MAX_ENTRY_BITS{1'b1}} << width_reg);
    assign idx_ext    = {{INDEX_W{1'b0}}, idx};
    assign cnt_ext    = {{BLOCK_NUM_W{1'b0}}, cnt_reg};

    always_comb begin
        state_next   = state_reg;
        palette_next = palette_reg;
        width_next   = width_reg;
        per_next     = per_reg;
        remain_next  = remain_reg;
        cnt_next     = cnt_reg;
        word_next    = word_reg;
        pidx_next    = pidx_reg;
        bnum_next    = bnum_reg;
        oop_next     = oop_reg;
        low_next     = low_reg;
        los_next     = los_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;

        if (cfg_wr_en) begin
            palette_next = cfg_wr_data;
            width_next   = entry_width(cfg_wr_data, MAX_ENTRY_BITS);
            per_next     = entries_per_word(width_next);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    word_next   = s_tdata;
                    remain_next = per_reg;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    pidx_next    = idx_ext[INDEX_W-1:0];
                    bnum_next    = cnt_ext[BLOCK_NUM_W-1:0];
                    oop_next     = (CMP_W'(idx) >= CMP_W'(palette_reg));
                    low_next     = last_entry;
                    los_next     = sec_end;
                    word_next    = word_reg >> width_reg;
                    remain_next  = remain_reg - REM_W'(1);
                    cnt_next     = sec_end ? '0 : cnt_reg + CNT_W'(1);
                    if (last_entry) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            palette_reg <= PALETTE_SIZE_RESET;
            width_reg   <= entry_width(PALETTE_SIZE_RESET, MAX_ENTRY_BITS);
            per_reg     <= entries_per_word(entry_width(PALETTE_SIZE_RESET, MAX_ENTRY_BITS));
            remain_reg  <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            palette_reg <= palette_next;
            width_reg   <= width_next;
            per_reg     <= per_next;
            remain_reg  <= remain_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            word_reg    <= word_next;
            pidx_reg    <= pidx_next;
            bnum_reg    <= bnum_next;
            oop_reg     <= oop_next;
            low_reg     <= low_next;
            los_reg     <= los_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {bnum_reg, pidx_reg};
    assign m_tlast  = low_reg;
    assign m_tuser  = {los_reg, oop_reg};

    `PPIU_ASSERT_NEXT(a_accept_starts_run, s_tvalid && s_tready, state_reg == ST_RUN,
        "accepted word did not start unpacking")
    `PPIU_ASSERT(a_cnt_in_section, cnt_reg <= CNT_LAST, "block counter beyond section end")
    `PPIU_ASSERT(a_run_has_entries, (state_reg != ST_RUN) || (remain_reg != '0),
        "unpacking with no entries left")
    `PPIU_ASSERT_NEXT(a_section_wraps, emit && sec_end, cnt_reg == '0 && state_reg == ST_IDLE,
        "section end did not wrap counter and end the word")
    `PPIU_ASSERT(a_width_range, (width_reg >= WIDTH_W'(MIN_ENTRY_BITS))
        && (width_reg <= WIDTH_W'(MAX_ENTRY_BITS)), "entry width out of range")

endmodule

`default_nettype wire

/* tb/tb_packed_palette_index_unpacker_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_palette_index_unpacker_top
// Self-checking testbench for the packed palette index unpacker.
//
// Words go in on the s_ stream and every unpacked index beat is checked
// against a scoreboard model that tracks palette size, entry width and the
// section block counter. The run covers directed entry widths and palette
// extremes, a long receiver hold-off, and random phases with random palette
// sizes and random idling on both streams, running through section wraps.
// ----------------------------------------------------------------------------

module tb_packed_palette_index_unpacker_top;
    import ppiu_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SECTION_BLOCKS = BLOCKS_PER_SECTION_DEF;
    localparam int RANDOM_WORDS   = 145;

    typedef struct packed {
        logic [INDEX_W-1:0]     index;
        logic [BLOCK_NUM_W-1:0] block;
        logic                   oop;
        logic                   last_word;
        logic                   last_sec;
    } entry_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [PALETTE_W-1:0]   cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [WORD_BITS-1:0]   s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b1;
    logic [TDATA_W-1:0]     m_tdata;    // palette_index[11:0], block_number[23:12]
    logic                   m_tlast;    // last_of_word
    logic [TUSER_W-1:0]     m_tuser;    // out_of_palette[0], last_of_section[1]

    packed_palette_index_unpacker_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    entry_t               pending_entries[$];
    logic [PALETTE_W-1:0] model_palette = PALETTE_SIZE_RESET;
    logic [31:0]          model_block   = '0;

    int errors         = 0;
    int words_sent     = 0;
    int entries_seen   = 0;
    int palette_writes = 0;
    int section_wraps  = 0;
    int mid_word_wraps = 0;
    int cycle_count    = 0;

    int tx_mode      = 0;
    int rx_mode      = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_left   = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned width_for(logic [PALETTE_W-1:0] n);
        int unsigned w;
        w = 0;
        while (w < 16 && (32'd1 << w) < {19'd0, n}) w++;
        if (w < MIN_ENTRY_BITS) w = MIN_ENTRY_BITS;
        if (w > MAX_ENTRY_BITS_DEF) w = MAX_ENTRY_BITS_DEF;
        return w;
    endfunction

    // expected beats for one accepted word
    function automatic void unpack_word(logic [WORD_BITS-1:0] word);
        int unsigned    w;
        int unsigned    per;
        logic [63:0]    mask;
        logic [63:0]    idx;
        entry_t         e;
        bit             sec_end;
        w    = width_for(model_palette);
        per  = WORD_BITS / w;
        mask = (64'd1 << w) - 64'd1;
        for (int unsigned i = 0; i < per; i++) begin
            idx         = (word >> (i * w)) & mask;
            sec_end     = model_block >= SECTION_BLOCKS - 1;
            e.index     = idx[INDEX_W-1:0];
            e.block     = model_block[BLOCK_NUM_W-1:0];
            e.oop       = idx >= {51'd0, model_palette};
            e.last_word = sec_end || (i + 1 == per);
            e.last_sec  = sec_end;
            pending_entries.insert(pending_entries.size(), e);
            if (sec_end) begin
                model_block = '0;
                section_wraps++;
                if (i + 1 < per) mid_word_wraps++;
                break;
            end
            model_block++;
        end
    endfunction

    function automatic int short_or_long();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int tx_gap();
        if (tx_mode == 0 || $urandom_range(0, 99) < 70) return 0;
        return short_or_long();
    endfunction

    // random content, with some words filled at the palette boundary
    function automatic logic [WORD_BITS-1:0] make_word();
        logic [WORD_BITS-1:0] word;
        int unsigned          w;
        logic [15:0]          v;
        w = width_for(model_palette);
        case ($urandom_range(0, 9))
            0: word = '1;
            1: word = '0;
            2, 3: begin
                word = '0;
                for (int unsigned i = 0; i < WORD_BITS / w; i++) begin
                    v = 16'(model_palette) - 16'd1 + 16'($urandom_range(0, 1));
                    word = word | ((64'(v) & ((64'd1 << w) - 64'd1)) << (i * w));
                end
            end
            default: word = {$urandom, $urandom};
        endcase
        return word;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic send_word(input logic [WORD_BITS-1:0] word);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        unpack_word(word);
        words_sent++;
        gap = tx_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_palette(input logic [PALETTE_W-1:0] size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        model_palette = size;
        palette_writes++;
        @(posedge aclk);
    endtask

    // receiver: hold-off, random stalls, or always ready
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (rx_mode != 0 && $urandom_range(0, 99) < 20) begin
            stall_left = short_or_long() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        entry_t got;
        entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.index     = m_tdata[INDEX_W-1:0];
            got.block     = m_tdata[INDEX_W+BLOCK_NUM_W-1:INDEX_W];
            got.oop       = m_tuser[0];
            got.last_word = m_tlast;
            got.last_sec  = m_tuser[1];
            entries_seen++;
            if (pending_entries.size() == 0) begin
                report_mismatch("beat with nothing pending, index", got.index, 0);
            end else begin
                want = pending_entries.pop_front();
                if (got.index != want.index)
                    report_mismatch("palette_index", got.index, want.index);
                if (got.block != want.block)
                    report_mismatch("block_number", got.block, want.block);
                if (got.oop != want.oop)
                    report_mismatch("out_of_palette", got.oop, want.oop);
                if (got.last_word != want.last_word)
                    report_mismatch("last_of_word", got.last_word, want.last_word);
                if (got.last_sec != want.last_sec)
                    report_mismatch("last_of_section", got.last_sec, want.last_sec);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d beats still pending",
                 cycle_count, pending_entries.size());
        $display("*** FAILED ***");
        $finish;
    end

    // reset palette size of 16, no register write yet
    task automatic test_reset_palette();
        send_word('0);
        send_word('1);
        send_word(64'h0123_4567_89AB_CDEF);
        send_word(64'hA5A5_5A5A_F0F0_0F0F);
    endtask

    // each entry width, palette zero/one, saturation above 4096
    task automatic test_entry_widths();
        int sizes[20] = '{0, 1, 2, 16, 17, 32, 33, 64, 65, 256, 257, 512, 513,
                          1024, 1025, 2048, 2049, 4096, 4097, 8191};
        foreach (sizes[i]) begin
            wait_idle();
            write_palette(PALETTE_W'(sizes[i]));
            send_word((i % 2 == 0) ? '1 : make_word());
        end
    endtask

    // receiver holds off while words keep coming, input must stall
    task automatic test_output_backpressure();
        wait_idle();
        write_palette(13'd16);
        tx_mode      = 0;
        rx_mode      = 0;
        hold_request = 300;
        repeat (40) send_word(make_word());
    endtask

    // run to the end of the section so that it ends inside a word
    task automatic test_section_wrap();
        wait_idle();
        write_palette(13'd16);
        tx_mode = 1;
        rx_mode = 1;
        while (SECTION_BLOCKS - int'(model_block) > 16) send_word(make_word());
        if (SECTION_BLOCKS - int'(model_block) == 16) begin
            wait_idle();
            write_palette(13'd17);
            send_word(make_word());
            wait_idle();
            write_palette(13'd16);
        end
        send_word(make_word());
    endtask

    task automatic test_random_sections();
        int sent;
        int pick;
        logic [PALETTE_W-1:0] size;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 35)      size = PALETTE_W'($urandom_range(0, 16));
            else if (pick < 65) size = PALETTE_W'($urandom_range(17, 256));
            else if (pick < 85) size = PALETTE_W'($urandom_range(257, 4096));
            else if (pick < 90) size = PALETTE_W'($urandom_range(4097, 8191));
            else                size = PALETTE_W'(1 << $urandom_range(0, 12));
            write_palette(size);
            tx_mode = ($urandom_range(0, 2) != 0);
            rx_mode = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(5, 40)) begin
                send_word(make_word());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_palette();
        test_entry_widths();
        test_output_backpressure();
        test_section_wrap();
        test_random_sections();

        s_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Run: %0d words, %0d index beats, %0d palette writes, %0d cycles",
                 words_sent, entries_seen, palette_writes, cycle_count);
        $display("Sections wrapped %0d times, %0d of them inside a word",
                 section_wraps, mid_word_wraps);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ppiu_pkg.sv
rtl/packed_palette_index_unpacker_top.sv
tb/tb_packed_palette_index_unpacker_top.sv
